### hdl/mono_page_framebuffer_scanout_core_defines.svh
// Assertion macros used by the checker of the scanout core.
`ifndef MONO_PAGE_FRAMEBUFFER_SCANOUT_CORE_DEFINES_SVH
`define MONO_PAGE_FRAMEBUFFER_SCANOUT_CORE_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define MPFB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds from the cycle after the antecedent.
`define MPFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mpfb_pkg.sv
package mpfb_pkg;

  localparam int PAGE_COUNT   = 8;
  localparam int COLUMN_COUNT = 128;
  localparam int ROW_COUNT    = PAGE_COUNT * 8;
  localparam int FRAME_BYTES  = PAGE_COUNT * COLUMN_COUNT;
  localparam int HEADER_LEN   = 3;
  localparam int LINE_LEN     = COLUMN_COUNT + HEADER_LEN;

  localparam int ADDR_W = $clog2(FRAME_BYTES);
  localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int COL_W  = $clog2(COLUMN_COUNT);
  localparam int POS_W  = $clog2(LINE_LEN);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [7:0] CMD_PAGE     = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW  = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH = 8'h10;

  localparam logic [POS_W-1:0] POS_PAGE_CMD = POS_W'(0);
  localparam logic [POS_W-1:0] POS_LOW_CMD  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_HIGH_CMD = POS_W'(2);

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_SCAN  = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMN_OFFSET   = 1'b0,
    REG_VERTICAL_OFFSET = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

endpackage

### hdl/mono_page_framebuffer_scanout_core.sv
// Channel   | Ports                                              | Handshake
// ----------+----------------------------------------------------+----------------------
// request   | action, pixel_x, pixel_y, pixel_on                 | start high, busy low
// result    | byte_valid, out_byte, is_command, frame_last,      | done, one cycle,
//           | range_error                                        | no backpressure
// config    | wr_index, wr_data                                  | wr_en
//
// One request per cycle while busy is low; its result is registered through s1_valid, then shows with done.
// Each scan data byte or in-range pixel is one frame memory read and, for a pixel, one write
// in the following cycle; a read that hits the pending write takes the forwarded byte.
// After reset, busy stays high while the clearing pass zeroes the frame memory; config writes are taken throughout.
module mono_page_framebuffer_scanout_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action,
  input  logic [7:0]                      pixel_x,
  input  logic [7:0]                      pixel_y,
  input  logic                            pixel_on,
  output logic                            done,
  output logic                            byte_valid,
  output logic [7:0]                      out_byte,
  output logic                            is_command,
  output logic                            frame_last,
  output logic                            range_error,
  input  logic                            wr_en,
  input  logic [mpfb_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [mpfb_pkg::CFG_DATA_W-1:0] wr_data
);
  import mpfb_pkg::*;

  logic [3:0]        column_offset;
  logic [6:0]        vertical_offset;

  logic [PAGE_W-1:0] scan_page;
  logic [PAGE_W-1:0] scan_page_next;
  logic [POS_W-1:0]  scan_position;
  logic [POS_W-1:0]  scan_position_next;

  logic              accept;
  logic              is_scan;
  logic              pix_err;
  logic [PAGE_W-1:0] pix_page;
  logic [ADDR_W-1:0] pix_addr;
  logic              scan_data;
  logic [POS_W-1:0]  scan_col;
  logic [ADDR_W-1:0] scan_addr;
  logic [7:0]        header_byte;
  logic              line_end;
  logic              page_end;

  mem_rd_t           rd;
  mem_wr_t           wr;
  logic [7:0]        rd_data;
  logic              clearing;

  logic              s1_valid;
  logic              s1_scan;
  logic              s1_data;
  logic              s1_err;
  logic              s1_last;
  logic [ADDR_W-1:0] s1_addr;
  logic [2:0]        s1_bit;
  logic              s1_on;
  logic [7:0]        s1_byte;
  logic              s1_fwd;
  logic [7:0]        s1_fwd_data;

  logic [7:0]        mem_word;
  logic [7:0]        mask;
  logic [7:0]        merged;

  mpfb_frame_mem u_frame_mem (
    .clk      (clk),
    .rst      (rst),
    .rd       (rd),
    .rd_data  (rd_data),
    .wr       (wr),
    .clearing (clearing)
  );

  assign busy    = clearing;
  assign accept  = start & ~busy;
  assign is_scan = (action_t'(action) == ACT_SCAN);

  always_comb begin
    pix_err  = !(({1'b0, pixel_x} < 9'(COLUMN_COUNT)) && ({1'b0, pixel_y} < 9'(ROW_COUNT)));
    pix_page = PAGE_W'(PAGE_COUNT - 1) - PAGE_W'(pixel_y[7:3]);
    pix_addr = ADDR_W'(pix_page) * ADDR_W'(COLUMN_COUNT) + ADDR_W'(pixel_x[COL_W-1:0]);

    scan_data = (scan_position >= POS_W'(HEADER_LEN));
    scan_col  = scan_position - POS_W'(HEADER_LEN);
    scan_addr = ADDR_W'(scan_page) * ADDR_W'(COLUMN_COUNT) + ADDR_W'(scan_col);

    case (scan_position)
      POS_PAGE_CMD: header_byte = CMD_PAGE + 8'(scan_page);
      POS_LOW_CMD:  header_byte = CMD_COL_LOW + 8'(column_offset);
      POS_HIGH_CMD: header_byte = CMD_COL_HIGH + 8'(vertical_offset[6:3]);
      default:      header_byte = 8'h00;
    endcase

    line_end = (scan_position == POS_W'(LINE_LEN - 1));
    page_end = (scan_page == PAGE_W'(PAGE_COUNT - 1));

    scan_position_next = line_end ? '0 : scan_position + POS_W'(1);
    if (line_end) begin
      scan_page_next = page_end ? '0 : scan_page + PAGE_W'(1);
    end else begin
      scan_page_next = scan_page;
    end

    rd.en   = accept && (is_scan ? scan_data : !pix_err);
    rd.addr = is_scan ? scan_addr : pix_addr;
  end

  always_comb begin
    mem_word = s1_fwd ? s1_fwd_data : rd_data;
    mask     = 8'h80 >> s1_bit;
    merged   = s1_on ? (mem_word | mask) : (mem_word & ~mask);
    wr.en    = s1_valid && !s1_scan && !s1_err;
    wr.addr  = s1_addr;
    wr.data  = merged;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_offset   <= 4'd2;
      vertical_offset <= 7'd0;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_COLUMN_OFFSET:   column_offset   <= wr_data[3:0];
        REG_VERTICAL_OFFSET: vertical_offset <= wr_data[6:0];
        default:             ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_page     <= '0;
      scan_position <= '0;
    end else if (accept && is_scan) begin
      scan_page     <= scan_page_next;
      scan_position <= scan_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      done     <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_scan     <= is_scan;
      s1_data     <= is_scan && scan_data;
      s1_err      <= !is_scan && pix_err;
      s1_last     <= is_scan && line_end && page_end;
      s1_addr     <= rd.addr;
      s1_bit      <= pixel_y[2:0];
      s1_on       <= pixel_on;
      s1_byte     <= header_byte;
      s1_fwd      <= wr.en && rd.en && (rd.addr == wr.addr);
      s1_fwd_data <= merged;
    end
    byte_valid  <= s1_scan;
    out_byte    <= s1_scan ? (s1_data ? mem_word : s1_byte) : 8'h00;
    is_command  <= s1_scan && !s1_data;
    frame_last  <= s1_last;
    range_error <= s1_err;
  end

endmodule

### hdl/mpfb_frame_mem.sv
module mpfb_frame_mem (
  input  logic              clk,
  input  logic              rst,
  input  mpfb_pkg::mem_rd_t rd,
  output logic [7:0]        rd_data,
  input  mpfb_pkg::mem_wr_t wr,
  output logic              clearing
);
  import mpfb_pkg::*;

  logic [7:0]        mem [FRAME_BYTES];
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(FRAME_BYTES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'h00;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

### hdl/mpfb_checker.sv
`include "mono_page_framebuffer_scanout_core_defines.svh"

module mpfb_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic byte_valid,
  input logic is_command,
  input logic frame_last,
  input logic range_error
);

  `MPFB_ASSERT_NEXT(a_result_follows, clk, rst, start && !busy, ##1 done, "request lost")
  `MPFB_ASSERT_SAME(a_no_spurious, clk, rst, done, $past(start && !busy, 2), "result without request")
  `MPFB_ASSERT_SAME(a_scan_no_err, clk, rst, done && byte_valid, !range_error, "scan byte flagged")
  `MPFB_ASSERT_SAME(a_last_is_data, clk, rst, done && frame_last, byte_valid && !is_command, "bad frame end")

endmodule

bind mono_page_framebuffer_scanout_core mpfb_checker u_mpfb_checker (.*);
